// ===== rtl/bpdc_pkg.sv =====
package bpdc_pkg;

  // Widths fixed by the word layout.
  localparam int BTN_W            = 5;
  localparam int NUM_EVENT_FIELDS = 5;
  localparam int CNT_W            = 8;
  localparam int THR_W            = 8;
  localparam int DATA_W           = 32;
  localparam int ADDR_W           = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register reset values.
  localparam logic [THR_W-1:0] SHORT_THR_RST = 8'd3;
  localparam logic [THR_W-1:0] LONG_THR_RST  = 8'd200;

  // Register indexes, taken from the word address bit above the byte offset.
  localparam logic REG_SHORT_THR = 1'b0;
  localparam logic REG_LONG_THR  = 1'b1;

  // Action codes of an input word.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  // Control shared by every lane and the backlight unit.
  typedef struct packed {
    logic             accept;
    logic             clear;
    logic [THR_W-1:0] short_thr;
    logic [THR_W-1:0] long_thr;
  } lane_ctl_t;

endpackage

// ===== rtl/bpdc_in_if.sv =====
interface bpdc_in_if;
  import bpdc_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [BTN_W-1:0] buttons_pressed;
  logic             backlight_pressed;

  modport source (output valid, action, buttons_pressed, backlight_pressed, input ready);
  modport sink   (input valid, action, buttons_pressed, backlight_pressed, output ready);

endinterface

// ===== rtl/bpdc_out_if.sv =====
interface bpdc_out_if;
  import bpdc_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] event_0;
  logic [1:0] event_1;
  logic [1:0] event_2;
  logic [1:0] event_3;
  logic [1:0] event_4;
  logic       backlight_on;

  modport source (output valid, event_0, event_1, event_2, event_3, event_4, backlight_on,
                  input ready);
  modport sink   (input valid, event_0, event_1, event_2, event_3, event_4, backlight_on,
                  output ready);

endinterface

// ===== rtl/bpdc_lane.sv =====
module bpdc_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  bpdc_pkg::lane_ctl_t ctl,
  input  logic                down,
  output bpdc_pkg::event_t    ev_nxt
);
  import bpdc_pkg::*;

  logic [CNT_W-1:0] hold_r;
  logic [CNT_W-1:0] hold_nxt;
  event_t           ev_r;

  always_comb begin
    hold_nxt = hold_r;
    ev_nxt   = ev_r;
    if (ctl.clear) begin
      ev_nxt = EV_NONE;
    end else if (down) begin
      if (hold_r < ctl.long_thr) begin
        hold_nxt = hold_r + CNT_W'(1);
      end else begin
        ev_nxt = EV_LONG;
      end
    end else begin
      // A release between the two thresholds is a short press.
      if ((hold_r > ctl.short_thr) && (hold_r < ctl.long_thr)) begin
        ev_nxt = EV_SHORT;
      end
      hold_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
      ev_r   <= EV_NONE;
    end else if (ctl.accept) begin
      hold_r <= hold_nxt;
      ev_r   <= ev_nxt;
    end
  end

endmodule

// ===== rtl/bpdc_backlight.sv =====
module bpdc_backlight (
  input  logic                clk,
  input  logic                rst_n,
  input  bpdc_pkg::lane_ctl_t ctl,
  input  logic                down,
  output logic                lit_nxt
);
  import bpdc_pkg::*;

  logic [CNT_W-1:0] hold_r;
  logic [CNT_W-1:0] hold_nxt;
  logic             lit_r;

  always_comb begin
    hold_nxt = hold_r;
    lit_nxt  = lit_r;
    if (!ctl.clear) begin
      if (down) begin
        if (hold_r != CNT_MAX) begin
          hold_nxt = hold_r + CNT_W'(1);
        end
      end else begin
        if (hold_r > ctl.short_thr) begin
          lit_nxt = ~lit_r;
        end
        hold_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
      lit_r  <= 1'b0;
    end else if (ctl.accept) begin
      hold_r <= hold_nxt;
      lit_r  <= lit_nxt;
    end
  end

endmodule

// ===== rtl/bpdc_merge.sv =====
module bpdc_merge #(
  parameter int NUM_BUTTONS = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  bpdc_pkg::event_t lane_ev [NUM_BUTTONS],
  input  logic             lit_nxt,
  output logic             take_ok,
  bpdc_out_if.source       out_ch
);
  import bpdc_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [1:0] field_nxt [NUM_EVENT_FIELDS];
  logic [1:0] field_r   [NUM_EVENT_FIELDS];
  logic       lit_r;

  // Fields past the last lane read as no event.
  for (genvar k = 0; k < NUM_EVENT_FIELDS; k++) begin : g_field
    if (k < NUM_BUTTONS) begin : g_lane
      assign field_nxt[k] = lane_ev[k];
    end else begin : g_none
      assign field_nxt[k] = EV_NONE;
    end
  end

  assign take_ok   = !valid_r || out_ch.ready;
  assign valid_nxt = accept || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      field_r <= field_nxt;
      lit_r   <= lit_nxt;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.event_0      = field_r[0];
  assign out_ch.event_1      = field_r[1];
  assign out_ch.event_2      = field_r[2];
  assign out_ch.event_3      = field_r[3];
  assign out_ch.event_4      = field_r[4];
  assign out_ch.backlight_on = lit_r;

endmodule

// ===== rtl/button_press_duration_classifier_core.sv =====
// Channel   Dir  Word
// in_ch     in   action, buttons_pressed[4:0], backlight_pressed
// out_ch    out  event_0..event_4 (2 bits each), backlight_on
// cfg (APB) in   short_threshold at 0x0, long_threshold at 0x4
//
// One input word is taken per clock cycle while input ready is high; its result
// appears in the output register on the next cycle. Each button lane compares
// its hold count with the thresholds and may increment it for each word.
// The output register is the only buffer: input ready is high whenever that
// register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous) clears all hold counts, latched events and
// the backlight, and restores both thresholds to 3 and 200.
module button_press_duration_classifier_core #(
  parameter int NUM_BUTTONS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bpdc_in_if.sink                       in_ch,
  bpdc_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpdc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bpdc_pkg::DATA_W-1:0]   pwdata,
  output logic [bpdc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import bpdc_pkg::*;

  // Threshold registers. The register index is the word address bit.
  logic [THR_W-1:0] short_thr_r;
  logic [THR_W-1:0] short_thr_nxt;
  logic [THR_W-1:0] long_thr_r;
  logic [THR_W-1:0] long_thr_nxt;
  logic             cfg_wr;
  logic             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_comb begin
    short_thr_nxt = short_thr_r;
    long_thr_nxt  = long_thr_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_SHORT_THR: short_thr_nxt = pwdata[THR_W-1:0];
        REG_LONG_THR:  long_thr_nxt  = pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_thr_r <= SHORT_THR_RST;
      long_thr_r  <= LONG_THR_RST;
    end else begin
      short_thr_r <= short_thr_nxt;
      long_thr_r  <= long_thr_nxt;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SHORT_THR: prdata = DATA_W'(short_thr_r);
      REG_LONG_THR:  prdata = DATA_W'(long_thr_r);
      default:       prdata = '0;
    endcase
  end

  // Input handshake and the control every lane sees.
  lane_ctl_t ctl;
  logic      take_ok;

  assign in_ch.ready   = take_ok;
  assign ctl.accept    = in_ch.valid && take_ok;
  assign ctl.clear     = (in_ch.action == ACT_CLEAR);
  assign ctl.short_thr = short_thr_r;
  assign ctl.long_thr  = long_thr_r;

  // One lane per button. Lanes past the input width never see a press.
  event_t lane_ev [NUM_BUTTONS];

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic down;
    if (i < BTN_W) begin : g_wired
      assign down = in_ch.buttons_pressed[i];
    end else begin : g_idle
      assign down = 1'b0;
    end

    bpdc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .down   (down),
      .ev_nxt (lane_ev[i])
    );
  end

  // The backlight button toggles its flag on a release past the short threshold.
  logic lit_nxt;

  bpdc_backlight u_backlight (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .down    (in_ch.backlight_pressed),
    .lit_nxt (lit_nxt)
  );

  // The merge stage gathers the lane results into the output register.
  bpdc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (ctl.accept),
    .lane_ev (lane_ev),
    .lit_nxt (lit_nxt),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpdc_pkg::*;

  // The run is cut off here if the words stop flowing. The slowest correct
  // run is about 1450 words, each with a bounded random gap on both sides, so
  // this leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Everything the block shows for one word: five latched events and the
  // backlight level.
  typedef struct packed {
    logic [NUM_EVENT_FIELDS-1:0][1:0] ev;
    logic                             lit;
  } panel_t;

  // Tracks the block's state alongside it. Every accepted word advances the
  // tracked state and queues the panel that must come out for it. Every
  // result taken from the block is compared with the oldest queued panel.
  class press_tracker;
    logic [THR_W-1:0] short_thr;
    logic [THR_W-1:0] long_thr;
    logic [CNT_W-1:0] hold [BTN_W];
    event_t           latched [BTN_W];
    logic [CNT_W-1:0] bl_hold;
    logic             lit;
    panel_t           pending_panels [$];
    int unsigned      mismatches;
    int unsigned      results;
    int unsigned      samples;
    int unsigned      clears;
    int unsigned      shorts;
    int unsigned      longs;
    int unsigned      toggles;
    int unsigned      settings;

    function new();
      short_thr = SHORT_THR_RST;
      long_thr  = LONG_THR_RST;
      foreach (hold[i]) begin
        hold[i]    = '0;
        latched[i] = EV_NONE;
      end
      bl_hold  = '0;
      lit      = 1'b0;
      settings = 1;
    endfunction

    function void set_register(logic idx, logic [THR_W-1:0] value);
      if (idx == REG_SHORT_THR) begin
        short_thr = value;
      end else begin
        long_thr = value;
      end
    endfunction

    function void note_word(logic act, logic [BTN_W-1:0] btn, logic bl);
      panel_t want;
      if (act == ACT_CLEAR) begin
        foreach (latched[i]) latched[i] = EV_NONE;
        clears++;
      end else begin
        samples++;
        for (int i = 0; i < BTN_W; i++) begin
          if (btn[i]) begin
            if (hold[i] < long_thr) begin
              hold[i] = hold[i] + 1'b1;
            end else begin
              if (latched[i] != EV_LONG) longs++;
              latched[i] = EV_LONG;
            end
          end else begin
            if (hold[i] > short_thr && hold[i] < long_thr) begin
              latched[i] = EV_SHORT;
              shorts++;
            end
            hold[i] = '0;
          end
        end
        if (bl) begin
          if (bl_hold != CNT_MAX) bl_hold = bl_hold + 1'b1;
        end else begin
          if (bl_hold > short_thr) begin
            lit = ~lit;
            toggles++;
          end
          bl_hold = '0;
        end
      end
      for (int i = 0; i < NUM_EVENT_FIELDS; i++) want.ev[i] = latched[i];
      want.lit = lit;
      pending_panels.push_back(want);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("tb_top: mismatch at result %0d: %s", results, msg);
    endfunction

    function void check_panel(panel_t seen);
      panel_t want;
      if (pending_panels.size() == 0) begin
        report("result arrived with no word outstanding");
        return;
      end
      want = pending_panels.pop_front();
      for (int i = 0; i < NUM_EVENT_FIELDS; i++) begin
        if (seen.ev[i] !== want.ev[i]) begin
          report($sformatf("event_%0d expected %0d, got %0d", i, want.ev[i], seen.ev[i]));
        end
      end
      if (seen.lit !== want.lit) begin
        report($sformatf("backlight_on expected %0d, got %0d", want.lit, seen.lit));
      end
      results++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  bpdc_in_if  in_ch ();
  bpdc_out_if out_ch ();

  button_press_duration_classifier_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  press_tracker sb = new();

  // Idling state of both sides. Every 40 words a side may switch to a
  // stretch without gaps, so back-to-back traffic is seen as well.
  bit          steady_in;
  bit          steady_out;
  int unsigned sent_words;
  int unsigned cycle_count;

  // Gesture state of the five buttons and, at index BTN_W, the backlight
  // button: whether the lane is held and for how many more words.
  bit          lane_down [BTN_W+1];
  int unsigned lane_left [BTN_W+1];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A cycle counter bounds the run; reaching the limit means the block
  // stopped moving words.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: timeout after %0d cycles", cycle_count);
    $display("tb_top: done, errors");
    $finish;
  end

  // Offers one word and holds it until the block takes it. The valid line
  // is only lowered when a gap follows, so it never drops and rises again
  // within one time step. The tracker is told of the word at the edge where
  // it was accepted.
  task automatic send_word(input logic act, input logic [BTN_W-1:0] btn, input logic bl);
    int unsigned gap;
    if (sent_words % 40 == 0) steady_in = ($urandom_range(0, 3) == 0);
    gap = steady_in ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.action            <= act;
    in_ch.buttons_pressed   <= btn;
    in_ch.backlight_pressed <= bl;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(act, btn, bl);
    sent_words++;
  endtask

  // Stops offering words and waits until every queued panel has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_panels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One APB write: a setup phase, then an access phase held until pready.
  // The upper data bits carry noise, since only the low byte is a register.
  task automatic write_threshold(input logic idx, input logic [THR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Chooses how long a lane stays held. Most spans sit right at the
  // thresholds, where a release flips between none, short and long. The
  // backlight now and then holds for 250 to 300 words to hit its saturation.
  function automatic int unsigned pick_hold_span(bit backlight);
    int s;
    int l;
    int span;
    s = sb.short_thr;
    l = sb.long_thr;
    if (backlight && $urandom_range(0, 11) == 0) return $urandom_range(250, 300);
    case ($urandom_range(0, 7))
      0: span = 1;
      1: span = s;
      2: span = s + 1;
      3: span = l - 1;
      4: span = l;
      5: span = l + 1;
      6: span = $urandom_range(1, l + 3);
      default: span = $urandom_range(1, 8);
    endcase
    if (span < 1) span = 1;
    return span;
  endfunction

  // Plays random press and release gestures on all lanes at once. A few
  // words are clears or pure noise on the levels, which breaks sequences
  // in the middle.
  task automatic play_gestures(input int unsigned count);
    int unsigned      pick;
    logic [BTN_W-1:0] levels;
    foreach (lane_left[i]) lane_left[i] = 0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        send_word(ACT_CLEAR, BTN_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      end else if (pick < 12) begin
        send_word(ACT_SAMPLE, BTN_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      end else begin
        for (int i = 0; i <= BTN_W; i++) begin
          if (lane_left[i] == 0) begin
            lane_down[i] = !lane_down[i];
            lane_left[i] = lane_down[i] ? pick_hold_span(i == BTN_W) : $urandom_range(1, 4);
          end
          lane_left[i]--;
        end
        for (int i = 0; i < BTN_W; i++) levels[i] = lane_down[i];
        send_word(ACT_SAMPLE, levels, lane_down[BTN_W]);
      end
    end
  endtask

  // Result side: draws a stall before each result, then takes it at the
  // first edge where the block shows valid.
  initial begin
    int unsigned stall;
    int unsigned taken;
    panel_t      seen;
    out_ch.ready <= 1'b0;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 40 == 0) steady_out = ($urandom_range(0, 3) == 0);
      stall = steady_out ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      seen.ev[0] = out_ch.event_0;
      seen.ev[1] = out_ch.event_1;
      seen.ev[2] = out_ch.event_2;
      seen.ev[3] = out_ch.event_3;
      seen.ev[4] = out_ch.event_4;
      seen.lit   = out_ch.backlight_on;
      sb.check_panel(seen);
      taken++;
    end
  end

  // Stimulus. The first phase runs at the reset thresholds; each later
  // phase writes both thresholds while the block is idle. The settings
  // reach both ends of each register, including a long threshold of zero.
  initial begin
    logic [THR_W-1:0] phase_short [7];
    logic [THR_W-1:0] phase_long [7];
    int unsigned      phase_words [7];
    phase_short = '{8'd3,   8'd0, 8'd2, 8'd0, 8'd255, 8'd5,  8'd1};
    phase_long  = '{8'd200, 8'd1, 8'd6, 8'd0, 8'd255, 8'd12, 8'd40};
    phase_words = '{300, 120, 200, 100, 350, 200, 150};

    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.action            <= ACT_SAMPLE;
    in_ch.buttons_pressed   <= '0;
    in_ch.backlight_pressed <= 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    sent_words = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset thresholds. All lanes held for five words
    // and released give a short press everywhere and toggle the backlight.
    send_word(ACT_SAMPLE, 5'b00000, 1'b0);
    repeat (5) send_word(ACT_SAMPLE, 5'b11111, 1'b1);
    send_word(ACT_SAMPLE, 5'b00000, 1'b0);
    // A clear ignores the levels it carries and leaves the counts alone.
    send_word(ACT_CLEAR, 5'b11111, 1'b1);
    send_word(ACT_SAMPLE, 5'b00000, 1'b0);
    // Four held words exceed the short threshold; three do not.
    repeat (4) send_word(ACT_SAMPLE, 5'b10101, 1'b0);
    repeat (3) send_word(ACT_SAMPLE, 5'b01010, 1'b1);
    send_word(ACT_SAMPLE, 5'b00000, 1'b0);
    send_word(ACT_CLEAR, 5'b00000, 1'b0);
    send_word(ACT_SAMPLE, 5'b00000, 1'b0);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        drain_results();
        write_threshold(REG_SHORT_THR, phase_short[p]);
        write_threshold(REG_LONG_THR, phase_long[p]);
        sb.settings++;
      end
      if (p == 2) begin
        // Halfway through, the sender waits for the block to empty out
        // completely before it continues.
        play_gestures(phase_words[p] / 2);
        drain_results();
        play_gestures(phase_words[p] - phase_words[p] / 2);
      end else begin
        play_gestures(phase_words[p]);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("tb_top: %0d sample words and %0d clears over %0d threshold settings",
             sb.samples, sb.clears, sb.settings);
    $display("tb_top: %0d short and %0d long presses latched, backlight toggled %0d times",
             sb.shorts, sb.longs, sb.toggles);
    if (sb.mismatches == 0 && sb.pending_panels.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches, %0d results missing",
               sb.mismatches, sb.pending_panels.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
